// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PHCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication between two conditions in the same cycle.
`define PHCE_ASSERT_IMPLY(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

`endif

// ===== rtl/phce_pkg.sv =====
package phce_pkg;

  // Work memory geometry.
  localparam int MEM_DEPTH   = 65536;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);
  localparam int DRIVE_COUNT = 2;
  localparam int PARAM_DEPTH = 8;
  localparam int PARAM_AW    = $clog2(PARAM_DEPTH);

  // Fixed work memory addresses.
  localparam logic [15:0] A_DATA_BUF   = 16'h4000;
  localparam logic [15:0] A_SECT_COUNT = 16'h7f08;
  localparam logic [15:0] A_STATUS     = 16'h7f14;
  localparam logic [15:0] A_DISK_MODE  = 16'h7f44;
  localparam logic [15:0] A_DM_N       = 16'h7f52;

  // Port C bit positions.
  localparam int M_ATN = 7;
  localparam int M_DAC = 6;
  localparam int M_RFD = 5;
  localparam int M_DAV = 4;
  localparam int S_DAC = 2;
  localparam int S_RFD = 1;
  localparam int S_DAV = 0;

  // Port access codes.
  localparam logic [2:0] OP_WR_B   = 3'd0;
  localparam logic [2:0] OP_WR_CHI = 3'd1;
  localparam logic [2:0] OP_BSR    = 3'd2;
  localparam logic [2:0] OP_RD_A   = 3'd3;
  localparam logic [2:0] OP_RD_C   = 3'd4;

  // Command codes.
  localparam logic [7:0] CMD_INIT    = 8'h00;
  localparam logic [7:0] CMD_WRITE   = 8'h01;
  localparam logic [7:0] CMD_READ    = 8'h02;
  localparam logic [7:0] CMD_SENDBUF = 8'h03;
  localparam logic [7:0] CMD_STATUS  = 8'h06;
  localparam logic [7:0] CMD_RECVMEM = 8'h0c;
  localparam logic [7:0] CMD_0D      = 8'h0d;
  localparam logic [7:0] CMD_0E      = 8'h0e;
  localparam logic [7:0] CMD_17      = 8'h17;
  localparam logic [7:0] CMD_SETMODE = 8'h1f;
  localparam logic [7:0] CMD_GETMODE = 8'h20;
  localparam logic [7:0] CMD_21      = 8'h21;
  localparam logic [7:0] CMD_READY   = 8'h23;
  localparam logic [7:0] CMD_QUIET   = 8'h25;
  localparam logic [7:0] CMD_26      = 8'h26;

  typedef enum logic [4:0] {
    CP_CMD  = 5'b00001,
    CP_DATA = 5'b00010,
    CP_EXEC = 5'b00100,
    CP_SEND = 5'b01000,
    CP_END  = 5'b10000
  } cycle_t;

  typedef enum logic [7:0] {
    HS_STOP = 8'b00000001,
    HS_ATN  = 8'b00000010,
    HS_CMD  = 8'b00000100,
    HS_DATA = 8'b00001000,
    HS_DAVR = 8'b00010000,
    HS_RFD  = 8'b00100000,
    HS_DAC  = 8'b01000000,
    HS_DACR = 8'b10000000
  } hshake_t;

  typedef enum logic [2:0] {
    CT_CLEAR = 3'b001,
    CT_IDLE  = 3'b010,
    CT_RUN   = 3'b100
  } ctl_t;

  // A 16-bit address selects the entry at that address modulo the depth.
  function automatic logic [MEM_AW-1:0] mem_index(input logic [15:0] addr);
    return addr[MEM_AW-1:0];
  endfunction

endpackage

// ===== rtl/parallel_handshake_command_engine_core.sv =====
// Disk-subsystem side of a four-wire parallel handshake with a command engine.
// Input channel (in_valid, in_stall): one main-side port access per transfer,
// carrying opcode, data_byte and drive_ready. Output channel (out_valid,
// out_stall): one result per access with read_value, data_to_main and
// port_c_value. Port reads and ignored writes finish in the cycle of the
// transfer, and their result is registered into the output buffer. A write
// that starts the sequencer runs it one move per cycle until it must wait
// for the main side; each work memory read (send buffer bytes, status, disk
// mode) adds a move, as does each drive beyond the first for the init
// command. The single-port work memory has a registered read output.
// A two-entry output buffer lets the next access be taken while a result is
// still waiting, so a stalled receiver only holds the input off once both
// entries are full. After reset the block clears the 64 KiB work memory,
// one entry a cycle, with in_stall high; all handshake state returns to its
// idle values.
module parallel_handshake_command_engine_core
  import phce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [7:0] data_byte,
  input  logic [1:0] drive_ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_value,
  output logic [7:0] data_to_main,
  output logic [7:0] port_c_value
);

`include "assert_macros.svh"

  // Work memory.
  logic [7:0]        mem [MEM_DEPTH];
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  // Sequencer state.
  ctl_t        ctl, ctl_next;
  logic [MEM_AW-1:0] clr, clr_next;
  cycle_t      cph, cph_next;
  hshake_t     hph, hph_next;
  logic [7:0]  cmd, cmd_next;
  logic        taken, taken_next;
  logic [16:0] to_recv, to_recv_next;
  logic [15:0] rptr, rptr_next;
  logic [17:0] to_send, to_send_next;
  logic [15:0] sptr, sptr_next;
  logic [7:0]  prm [PARAM_DEPTH];
  logic [7:0]  prm_next [PARAM_DEPTH];
  logic [7:0]  pa, pa_next, pb, pb_next, pc, pc_next;
  logic        recv_mem, recv_mem_next, send_mem, send_mem_next;
  logic [1:0]  rdy, rdy_next;
  logic [1:0]  sub, sub_next;
  logic [1:0]  dm_n, dm_n_next;

  // Output buffer.
  logic        ov, sv;
  logic [7:0]  o_rv, o_a, o_c, s_rv, s_a, s_c;
  logic        push, pop, accept, stop;
  logic [7:0]  push_rv;

  logic [7:0]  d;
  logic        d_ok;

  assign d        = prm[0];
  assign d_ok     = (d < 8'(DRIVE_COUNT));
  assign in_stall = (ctl != CT_IDLE) || sv;
  assign accept   = in_valid && !in_stall;
  assign pop      = ov && !out_stall;

  // Access handling and one sequencer move per cycle.
  always_comb begin
    ctl_next      = ctl;
    clr_next      = clr;
    cph_next      = cph;
    hph_next      = hph;
    cmd_next      = cmd;
    taken_next    = taken;
    to_recv_next  = to_recv;
    rptr_next     = rptr;
    to_send_next  = to_send;
    sptr_next     = sptr;
    prm_next      = prm;
    pa_next       = pa;
    pb_next       = pb;
    pc_next       = pc;
    recv_mem_next = recv_mem;
    send_mem_next = send_mem;
    rdy_next      = rdy;
    sub_next      = 2'd0;
    dm_n_next     = dm_n;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = '0;
    raddr         = '0;
    wdata         = 8'h00;
    push          = 1'b0;
    push_rv       = 8'h00;
    stop          = 1'b0;

    case (ctl)
      CT_CLEAR: begin
        mem_we   = 1'b1;
        waddr    = clr;
        clr_next = clr + 1'b1;
        if (&clr) begin
          ctl_next = CT_IDLE;
        end
      end

      CT_IDLE: begin
        if (accept) begin
          rdy_next = drive_ready;
          push     = 1'b1;
          case (opcode)
            OP_WR_B: begin
              pb_next  = data_byte;
              push     = 1'b0;
              ctl_next = CT_RUN;
            end
            OP_WR_CHI: begin
              pc_next  = {data_byte[7:4], pc[3:0]};
              push     = 1'b0;
              ctl_next = CT_RUN;
            end
            OP_BSR: begin
              // Only the main-side bits may be set or cleared.
              if (!data_byte[7] && data_byte[3]) begin
                pc_next[{1'b1, data_byte[2:1]}] = data_byte[0];
                push     = 1'b0;
                ctl_next = CT_RUN;
              end
            end
            OP_RD_A: push_rv = pa;
            OP_RD_C: push_rv = pc;
            default: push_rv = 8'h00;
          endcase
        end
      end

      CT_RUN: begin
        case (cph)
          CP_CMD, CP_DATA: begin
            if (hph == HS_ATN && cph == CP_CMD) begin
              if (!pc[M_ATN]) begin
                stop = 1'b1;
              end else begin
                pc_next[S_RFD] = 1'b1;
                hph_next       = HS_CMD;
              end
            end else if (hph == HS_CMD && cph == CP_CMD) begin
              if (!pc[M_DAV]) begin
                stop = 1'b1;
              end else begin
                pc_next[S_RFD] = 1'b0;
                pc_next[S_DAC] = 1'b1;
                cmd_next       = pb;
                taken_next     = 1'b1;
                hph_next       = HS_DAVR;
              end
            end else if (hph == HS_DATA && cph == CP_DATA) begin
              if (!pc[M_DAV]) begin
                stop = 1'b1;
              end else begin
                pc_next[S_RFD] = 1'b0;
                pc_next[S_DAC] = 1'b1;
                if (recv_mem) begin
                  mem_we = 1'b1;
                  waddr  = mem_index(rptr);
                  wdata  = pb;
                end else begin
                  prm_next[rptr[PARAM_AW-1:0]] = pb;
                end
                rptr_next    = rptr + 16'd1;
                to_recv_next = to_recv - 17'd1;
                hph_next     = HS_DAVR;
              end
            end else if (hph == HS_DAVR) begin
              if (pc[M_DAV]) begin
                stop = 1'b1;
              end else begin
                pc_next[S_DAC] = 1'b0;
                hph_next       = HS_STOP;
              end
            end else if (hph != HS_STOP) begin
              hph_next = HS_STOP;
            end else if (cph == CP_CMD) begin
              if (taken) begin
                // Set up the parameter count for the new command.
                to_recv_next = 17'd0;
                cph_next     = CP_DATA;
                case (cmd)
                  CMD_WRITE, CMD_RECVMEM, CMD_READ, CMD_0D, CMD_SETMODE, CMD_26, CMD_0E,
                  CMD_17, CMD_GETMODE, CMD_21, CMD_READY: begin
                    rptr_next     = 16'd0;
                    recv_mem_next = 1'b0;
                    case (cmd)
                      CMD_WRITE, CMD_RECVMEM: begin
                        to_recv_next = 17'd4;
                        prm_next[5]  = 8'h00;
                      end
                      CMD_READ:                    to_recv_next = 17'd4;
                      CMD_0D, CMD_SETMODE, CMD_26: to_recv_next = 17'd2;
                      CMD_0E:                      to_recv_next = 17'd6;
                      default:                     to_recv_next = 17'd1;
                    endcase
                  end
                  default: to_recv_next = 17'd0;
                endcase
              end else begin
                hph_next = HS_ATN;
              end
            end else if (to_recv != 17'd0) begin
              pc_next[S_RFD] = 1'b1;
              hph_next       = HS_DATA;
            end else begin
              cph_next = CP_EXEC;
            end
          end

          CP_EXEC: begin
            // Most commands complete in one move; each memory read adds a move.
            cph_next     = CP_SEND;
            to_send_next = 18'd0;
            case (cmd)
              CMD_INIT: begin
                mem_we = 1'b1;
                waddr  = mem_index(A_DISK_MODE + 16'(sub));
                wdata  = 8'h01;
                if (sub != 2'(DRIVE_COUNT - 1)) begin
                  sub_next     = sub + 2'd1;
                  cph_next     = cph;
                  to_send_next = to_send;
                end
              end
              CMD_WRITE: begin
                if (prm[5] == 8'h00) begin
                  to_recv_next = {1'b0, prm[0], 8'h00};
                  if (prm[0] != 8'h00) begin
                    rptr_next     = A_DATA_BUF;
                    recv_mem_next = 1'b1;
                    cph_next      = CP_DATA;
                    prm_next[5]   = 8'h01;
                  end
                end
              end
              CMD_SENDBUF: begin
                if (sub == 2'd0) begin
                  mem_re       = 1'b1;
                  raddr        = mem_index(A_DM_N);
                  sub_next     = 2'd1;
                  cph_next     = cph;
                  to_send_next = to_send;
                end else if (sub == 2'd1) begin
                  dm_n_next    = rdata[1:0];
                  mem_re       = 1'b1;
                  raddr        = mem_index(A_SECT_COUNT);
                  sub_next     = 2'd2;
                  cph_next     = cph;
                  to_send_next = to_send;
                end else begin
                  to_send_next  = 18'(rdata) << (4'd7 + 4'(dm_n));
                  sptr_next     = A_DATA_BUF;
                  send_mem_next = 1'b1;
                end
              end
              CMD_STATUS: begin
                if (sub == 2'd0) begin
                  mem_re       = 1'b1;
                  raddr        = mem_index(A_STATUS);
                  sub_next     = 2'd1;
                  cph_next     = cph;
                  to_send_next = to_send;
                end else begin
                  prm_next[0]   = rdata;
                  to_send_next  = 18'd1;
                  sptr_next     = 16'd0;
                  send_mem_next = 1'b0;
                end
              end
              CMD_RECVMEM: begin
                if (prm[5] == 8'h00) begin
                  rptr_next     = {prm[0], prm[1]};
                  to_recv_next  = {1'b0, prm[2], prm[3]};
                  recv_mem_next = 1'b1;
                  cph_next      = CP_DATA;
                  prm_next[5]   = 8'h01;
                end
              end
              CMD_SETMODE: begin
                if (d_ok) begin
                  mem_we = 1'b1;
                  waddr  = mem_index(A_DISK_MODE + 16'(d[1:0]));
                  wdata  = prm[1];
                end
              end
              CMD_GETMODE: begin
                if (d_ok && sub == 2'd0) begin
                  mem_re       = 1'b1;
                  raddr        = mem_index(A_DISK_MODE + 16'(d[1:0]));
                  sub_next     = 2'd1;
                  cph_next     = cph;
                  to_send_next = to_send;
                end else begin
                  prm_next[0]   = d_ok ? rdata : 8'hff;
                  to_send_next  = 18'd1;
                  sptr_next     = 16'd0;
                  send_mem_next = 1'b0;
                end
              end
              CMD_READY: begin
                prm_next[0]   = (d_ok && d < 8'd2 && rdy[d[0]]) ? 8'h00 : 8'hff;
                to_send_next  = 18'd1;
                sptr_next     = 16'd0;
                send_mem_next = 1'b0;
              end
              CMD_QUIET: begin
                prm_next[0]   = 8'h00;
                prm_next[1]   = 8'h00;
                to_send_next  = 18'd2;
                sptr_next     = 16'd0;
                send_mem_next = 1'b0;
              end
              default: begin
                to_send_next = 18'd0;
              end
            endcase
          end

          CP_SEND: begin
            if (hph == HS_RFD) begin
              if (!pc[M_RFD]) begin
                stop = 1'b1;
              end else if (send_mem && sub == 2'd0) begin
                mem_re   = 1'b1;
                raddr    = mem_index(sptr);
                sub_next = 2'd1;
              end else begin
                pa_next        = send_mem ? rdata : prm[sptr[PARAM_AW-1:0]];
                sptr_next      = sptr + 16'd1;
                to_send_next   = to_send - 18'd1;
                pc_next[S_DAV] = 1'b1;
                hph_next       = HS_DAC;
              end
            end else if (hph == HS_DAC) begin
              if (!pc[M_DAC]) begin
                stop = 1'b1;
              end else begin
                pc_next[S_DAV] = 1'b0;
                hph_next       = HS_DACR;
              end
            end else if (hph == HS_DACR) begin
              if (pc[M_DAC]) begin
                stop = 1'b1;
              end else begin
                hph_next = HS_STOP;
              end
            end else if (hph != HS_STOP) begin
              hph_next = HS_STOP;
            end else if (to_send != 18'd0) begin
              hph_next = HS_RFD;
            end else begin
              cph_next = CP_END;
            end
          end

          CP_END: begin
            cph_next   = CP_CMD;
            taken_next = 1'b0;
          end

          default: cph_next = CP_CMD;
        endcase

        if (stop) begin
          push     = 1'b1;
          ctl_next = CT_IDLE;
        end
      end

      default: ctl_next = CT_IDLE;
    endcase
  end

  // Work memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // Sequencer and port latches.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl      <= CT_CLEAR;
      clr      <= '0;
      cph      <= CP_CMD;
      hph      <= HS_STOP;
      cmd      <= 8'h00;
      taken    <= 1'b0;
      to_recv  <= 17'd0;
      rptr     <= 16'd0;
      to_send  <= 18'd0;
      sptr     <= 16'd0;
      for (int i = 0; i < PARAM_DEPTH; i++) begin
        prm[i] <= 8'h00;
      end
      pa       <= 8'h00;
      pb       <= 8'h00;
      pc       <= 8'h00;
      recv_mem <= 1'b0;
      send_mem <= 1'b0;
      rdy      <= 2'd0;
      sub      <= 2'd0;
      dm_n     <= 2'd0;
    end else begin
      ctl      <= ctl_next;
      clr      <= clr_next;
      cph      <= cph_next;
      hph      <= hph_next;
      cmd      <= cmd_next;
      taken    <= taken_next;
      to_recv  <= to_recv_next;
      rptr     <= rptr_next;
      to_send  <= to_send_next;
      sptr     <= sptr_next;
      prm      <= prm_next;
      pa       <= pa_next;
      pb       <= pb_next;
      pc       <= pc_next;
      recv_mem <= recv_mem_next;
      send_mem <= send_mem_next;
      rdy      <= rdy_next;
      sub      <= sub_next;
      dm_n     <= dm_n_next;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (push) begin
      if (!ov || pop) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end else if (pop) begin
      if (sv) begin
        sv <= 1'b0;
      end else begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!ov || pop) begin
        o_rv <= push_rv;
        o_a  <= pa_next;
        o_c  <= pc_next;
      end else begin
        s_rv <= push_rv;
        s_a  <= pa_next;
        s_c  <= pc_next;
      end
    end else if (pop && sv) begin
      o_rv <= s_rv;
      o_a  <= s_a;
      o_c  <= s_c;
    end
  end

  assign out_valid    = ov;
  assign read_value   = o_rv;
  assign data_to_main = o_a;
  assign port_c_value = o_c;

  // Checks on the output buffer and the memory port.
  `PHCE_ASSERT_IMPLY(a_skid_behind_out, sv, ov, "skid entry valid without output entry")
  `PHCE_ASSERT_IMPLY(a_push_has_room, push && ov && !pop, !sv, "result pushed into full buffer")
  `PHCE_ASSERT(a_one_mem_access, !(mem_re && mem_we), "work memory read and write together")

endmodule

// ===== test/tb_parallel_handshake_command_engine_core.sv =====
`timescale 1ns / 100ps

// Predicts the result of every port access from its own copy of the
// handshake sequencer, and holds those results until the block returns them.
class port_access_scoreboard;
  typedef struct {
    logic [7:0] rv;
    logic [7:0] dm;
    logic [7:0] pc;
  } access_result_t;

  access_result_t expected_results[$];
  int unsigned    mismatches;

  phce_pkg::cycle_t  cyc;
  phce_pkg::hshake_t hs;
  bit [7:0]    cmd;
  bit          taken;
  int unsigned rx_left;
  bit [15:0]   rx_ptr;
  int unsigned tx_left;
  bit [15:0]   tx_ptr;
  bit [7:0]    prm[8];
  bit [7:0]    pa, pb, pc;
  bit [7:0]    mem[65536];
  bit          rx_mem, tx_mem;
  bit [1:0]    ready;

  function new();
    cyc = phce_pkg::CP_CMD;
    hs  = phce_pkg::HS_STOP;
    cmd = 0; taken = 0; rx_left = 0; rx_ptr = 0; tx_left = 0; tx_ptr = 0;
    pa = 0; pb = 0; pc = 0; rx_mem = 0; tx_mem = 0; ready = 0;
    mismatches = 0;
    foreach (prm[i]) prm[i] = 0;
    foreach (mem[i]) mem[i] = 0;
  endfunction

  // Sets how many parameter bytes the command that was just taken needs.
  function void decode_command();
    rx_left = 0;
    case (cmd)
      phce_pkg::CMD_WRITE, phce_pkg::CMD_RECVMEM: begin
        rx_left = 4; prm[5] = 0;
      end
      phce_pkg::CMD_READ: rx_left = 4;
      phce_pkg::CMD_0D, phce_pkg::CMD_SETMODE, phce_pkg::CMD_26: rx_left = 2;
      phce_pkg::CMD_0E: rx_left = 6;
      phce_pkg::CMD_17, phce_pkg::CMD_GETMODE, phce_pkg::CMD_21, phce_pkg::CMD_READY:
        rx_left = 1;
      default: ;
    endcase
    if (rx_left != 0) begin
      rx_ptr = 0; rx_mem = 0;
    end
  endfunction

  function void reply_params(int unsigned n);
    tx_left = n; tx_ptr = 0; tx_mem = 0;
  endfunction

  // Executes the command once all its parameters are in.
  function void execute_command();
    bit [7:0] d;
    d = prm[0];
    cyc = phce_pkg::CP_SEND;
    tx_left = 0;
    case (cmd)
      phce_pkg::CMD_INIT:
        for (int i = 0; i < phce_pkg::DRIVE_COUNT; i++)
          mem[phce_pkg::A_DISK_MODE + 16'(i)] = 8'h01;
      phce_pkg::CMD_WRITE:
        if (prm[5] == 0) begin
          rx_left = 256 * prm[0];
          if (rx_left != 0) begin
            rx_ptr = phce_pkg::A_DATA_BUF; rx_mem = 1;
            cyc = phce_pkg::CP_DATA; prm[5] = 1;
          end
        end
      phce_pkg::CMD_SENDBUF: begin
        tx_left = (128 << (mem[phce_pkg::A_DM_N] & 3)) * mem[phce_pkg::A_SECT_COUNT];
        tx_ptr = phce_pkg::A_DATA_BUF; tx_mem = 1;
      end
      phce_pkg::CMD_STATUS: begin
        prm[0] = mem[phce_pkg::A_STATUS]; reply_params(1);
      end
      phce_pkg::CMD_RECVMEM:
        if (prm[5] == 0) begin
          rx_ptr = {prm[0], prm[1]};
          rx_left = {prm[2], prm[3]};
          rx_mem = 1; cyc = phce_pkg::CP_DATA; prm[5] = 1;
        end
      phce_pkg::CMD_SETMODE:
        if (d < phce_pkg::DRIVE_COUNT) mem[phce_pkg::A_DISK_MODE + 16'(d)] = prm[1];
      phce_pkg::CMD_GETMODE: begin
        prm[0] = (d < phce_pkg::DRIVE_COUNT) ? mem[phce_pkg::A_DISK_MODE + 16'(d)] : 8'hff;
        reply_params(1);
      end
      phce_pkg::CMD_READY: begin
        prm[0] = (d < phce_pkg::DRIVE_COUNT && d < 2 && ready[d[0]]) ? 8'h00 : 8'hff;
        reply_params(1);
      end
      phce_pkg::CMD_QUIET: begin
        prm[0] = 0; prm[1] = 0; reply_params(2);
      end
      default: ;
    endcase
  endfunction

  // One sequencer move; returns 0 when it has to wait for the main side.
  function bit sequencer_move();
    bit [7:0] c;
    c = pc;
    case (cyc)
      phce_pkg::CP_CMD, phce_pkg::CP_DATA: begin
        if (hs == phce_pkg::HS_ATN && cyc == phce_pkg::CP_CMD) begin
          if (!c[phce_pkg::M_ATN]) return 0;
          pc[phce_pkg::S_RFD] = 1; hs = phce_pkg::HS_CMD;
        end else if (hs == phce_pkg::HS_CMD && cyc == phce_pkg::CP_CMD) begin
          if (!c[phce_pkg::M_DAV]) return 0;
          pc[phce_pkg::S_RFD] = 0; cmd = pb; taken = 1;
          pc[phce_pkg::S_DAC] = 1; hs = phce_pkg::HS_DAVR;
        end else if (hs == phce_pkg::HS_DATA && cyc == phce_pkg::CP_DATA) begin
          if (!c[phce_pkg::M_DAV]) return 0;
          pc[phce_pkg::S_RFD] = 0;
          if (rx_mem) mem[rx_ptr] = pb;
          else prm[rx_ptr[2:0]] = pb;
          rx_ptr++; rx_left--;
          pc[phce_pkg::S_DAC] = 1; hs = phce_pkg::HS_DAVR;
        end else if (hs == phce_pkg::HS_DAVR) begin
          if (c[phce_pkg::M_DAV]) return 0;
          pc[phce_pkg::S_DAC] = 0; hs = phce_pkg::HS_STOP;
        end else if (hs != phce_pkg::HS_STOP) begin
          hs = phce_pkg::HS_STOP;
        end else if (cyc == phce_pkg::CP_CMD) begin
          if (taken) begin
            decode_command(); cyc = phce_pkg::CP_DATA;
          end else begin
            hs = phce_pkg::HS_ATN;
          end
        end else if (rx_left > 0) begin
          pc[phce_pkg::S_RFD] = 1; hs = phce_pkg::HS_DATA;
        end else begin
          cyc = phce_pkg::CP_EXEC;
        end
      end
      phce_pkg::CP_EXEC: execute_command();
      phce_pkg::CP_SEND: begin
        if (hs == phce_pkg::HS_RFD) begin
          if (!c[phce_pkg::M_RFD]) return 0;
          pa = tx_mem ? mem[tx_ptr] : prm[tx_ptr[2:0]];
          tx_ptr++; tx_left--;
          pc[phce_pkg::S_DAV] = 1; hs = phce_pkg::HS_DAC;
        end else if (hs == phce_pkg::HS_DAC) begin
          if (!c[phce_pkg::M_DAC]) return 0;
          pc[phce_pkg::S_DAV] = 0; hs = phce_pkg::HS_DACR;
        end else if (hs == phce_pkg::HS_DACR) begin
          if (c[phce_pkg::M_DAC]) return 0;
          hs = phce_pkg::HS_STOP;
        end else if (hs != phce_pkg::HS_STOP) begin
          hs = phce_pkg::HS_STOP;
        end else if (tx_left > 0) begin
          hs = phce_pkg::HS_RFD;
        end else begin
          cyc = phce_pkg::CP_END;
        end
      end
      phce_pkg::CP_END: begin
        cyc = phce_pkg::CP_CMD; taken = 0;
      end
      default: cyc = phce_pkg::CP_CMD;
    endcase
    return 1;
  endfunction

  function void run_sequencer();
    for (int i = 0; i < 256; i++)
      if (!sequencer_move()) break;
  endfunction

  // Notes an accepted port access and queues the result it must produce.
  function void note_access(bit [2:0] op, bit [7:0] data, bit [1:0] rdy);
    access_result_t r;
    bit [2:0] bitno;
    r.rv = 0;
    ready = rdy;
    case (op)
      phce_pkg::OP_WR_B: begin
        pb = data; run_sequencer();
      end
      phce_pkg::OP_WR_CHI: begin
        pc = {data[7:4], pc[3:0]}; run_sequencer();
      end
      phce_pkg::OP_BSR:
        if (!data[7]) begin
          bitno = data[3:1];
          if (bitno >= 4) begin
            pc[bitno] = data[0]; run_sequencer();
          end
        end
      phce_pkg::OP_RD_A: r.rv = pa;
      phce_pkg::OP_RD_C: r.rv = pc;
      default: ;
    endcase
    r.dm = pa;
    r.pc = pc;
    expected_results.push_back(r);
  endfunction

  // Compares one returned result with the oldest expected one.
  function void check_result(logic [7:0] rv, logic [7:0] dm, logic [7:0] pcv);
    access_result_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result rv=%h dm=%h pc=%h", $time, rv, dm, pcv);
      mismatches++;
      return;
    end
    e = expected_results.pop_front();
    if (rv !== e.rv) begin
      $display("%0t: read_value expected %h actual %h", $time, e.rv, rv);
      mismatches++;
    end
    if (dm !== e.dm) begin
      $display("%0t: data_to_main expected %h actual %h", $time, e.dm, dm);
      mismatches++;
    end
    if (pcv !== e.pc) begin
      $display("%0t: port_c_value expected %h actual %h", $time, e.pc, pcv);
      mismatches++;
    end
  endfunction
endclass

module tb_parallel_handshake_command_engine_core;
  import phce_pkg::*;

  localparam int          TARGET_ACCESSES = 850;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;

  typedef struct {
    bit [2:0] op;
    bit [7:0] data;
    bit [1:0] rdy;
  } port_access_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic [1:0] drive_ready;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_value;
  logic [7:0] data_to_main;
  logic [7:0] port_c_value;

  port_access_scoreboard access_sb;
  port_access_t          pending_accesses[$];
  int                    accepted_count;
  int                    hold_at;
  bit                    stimulus_done;
  int unsigned           cycle_count;

  parallel_handshake_command_engine_core dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .drive_ready  (drive_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_value   (read_value),
    .data_to_main (data_to_main),
    .port_c_value (port_c_value)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Idle percentages for each side follow the progress of the run.
  function automatic int sender_idle_pct();
    if (accepted_count < TARGET_ACCESSES / 3) return 37;
    if (accepted_count < 2 * TARGET_ACCESSES / 3) return 71;
    return 0;
  endfunction

  function automatic int receiver_stall_pct();
    if (accepted_count < TARGET_ACCESSES / 3) return 71;
    if (accepted_count < 2 * TARGET_ACCESSES / 3) return 37;
    return 0;
  endfunction

  function automatic bit [7:0] bit_set_reset(int bitno, bit value);
    return 8'(bitno * 2) | 8'(value);
  endfunction

  task automatic queue_access(bit [2:0] op, bit [7:0] data);
    port_access_t a;
    a.op = op;
    a.data = data;
    a.rdy = 2'($urandom_range(0, 3));
    pending_accesses.push_back(a);
  endtask

  // One byte handed over on port B with the DAV strobe.
  task automatic queue_byte_out(bit [7:0] b);
    queue_access(OP_WR_B, b);
    queue_access(OP_BSR, bit_set_reset(M_DAV, 1));
    queue_access(OP_BSR, bit_set_reset(M_DAV, 0));
  endtask

  // One byte fetched from port A with the RFD and DAC strobes.
  task automatic queue_byte_in();
    queue_access(OP_BSR, bit_set_reset(M_RFD, 1));
    queue_access(OP_RD_A, 8'($urandom));
    queue_access(OP_BSR, bit_set_reset(M_DAC, 1));
    queue_access(OP_RD_C, 8'($urandom));
    queue_access(OP_BSR, bit_set_reset(M_DAC, 0));
    queue_access(OP_BSR, bit_set_reset(M_RFD, 0));
  endtask

  // A whole command cycle: command byte, parameters, bulk data and reply.
  task automatic queue_command_cycle();
    bit [7:0] codes[15];
    bit [7:0] c;
    bit [7:0] p[8];
    int       nparam;
    int       nbulk;
    int       nreply;
    codes = '{CMD_INIT, CMD_WRITE, CMD_READ, CMD_SENDBUF, CMD_STATUS, CMD_RECVMEM,
              CMD_0D, CMD_0E, CMD_17, CMD_SETMODE, CMD_GETMODE, CMD_21, CMD_READY,
              CMD_QUIET, CMD_26};
    c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : codes[$urandom_range(0, 14)];
    foreach (p[i]) p[i] = 8'($urandom);
    nbulk = 0;
    nreply = $urandom_range(0, 2);
    case (c)
      CMD_WRITE, CMD_READ: nparam = 4;
      CMD_RECVMEM: nparam = 4;
      CMD_0D, CMD_SETMODE, CMD_26: nparam = 2;
      CMD_0E: nparam = 6;
      CMD_17, CMD_GETMODE, CMD_21, CMD_READY: nparam = 1;
      default: nparam = 0;
    endcase
    if (c == CMD_WRITE) begin
      p[0] = ($urandom_range(0, 30) == 0) ? 8'd1 : 8'd0;
      nbulk = (p[0] != 0) ? $urandom_range(4, 20) : 0;
    end
    if (c == CMD_RECVMEM) begin
      // Short transfers of one to four bytes, often aimed at the status and mode cells.
      case ($urandom_range(0, 5))
        0: {p[0], p[1]} = A_STATUS;
        1: {p[0], p[1]} = A_DISK_MODE;
        2: {p[0], p[1]} = A_DM_N;
        3: {p[0], p[1]} = 16'hfffe;
        default: ;
      endcase
      p[2] = 0;
      p[3] = 8'($urandom_range(1, 4));
      nbulk = p[3];
    end
    if (c == CMD_SETMODE || c == CMD_GETMODE || c == CMD_READY)
      p[0] = 8'($urandom_range(0, 3));
    if (c == CMD_STATUS || c == CMD_GETMODE || c == CMD_READY || c == CMD_QUIET)
      nreply = (c == CMD_QUIET) ? 2 : 1;
    queue_access(OP_WR_B, c);
    queue_access(OP_BSR, bit_set_reset(M_ATN, 1));
    queue_access(OP_BSR, bit_set_reset(M_DAV, 1));
    queue_access(OP_BSR, bit_set_reset(M_DAV, 0));
    for (int i = 0; i < nparam; i++) queue_byte_out(p[i]);
    for (int i = 0; i < nbulk; i++) queue_byte_out(8'($urandom));
    for (int i = 0; i < nreply; i++) queue_byte_in();
    if ($urandom_range(0, 3) == 0) queue_access(OP_BSR, bit_set_reset(M_ATN, 0));
  endtask

  task automatic build_stimulus();
    // Directed: every opcode at both data extremes, ignored bit set/reset
    // forms, and a high nibble write of all ones then all zeros.
    for (int op = 0; op < 8; op++) begin
      queue_access(3'(op), 8'h00);
      queue_access(3'(op), 8'hff);
    end
    queue_access(OP_BSR, 8'h80 | bit_set_reset(M_ATN, 1));
    queue_access(OP_BSR, bit_set_reset(1, 1));
    queue_access(OP_BSR, bit_set_reset(3, 1));
    queue_access(OP_WR_CHI, 8'hf0);
    queue_access(OP_WR_CHI, 8'h0f);
    queue_access(OP_RD_C, 8'h00);
    // Random: mostly well-formed command cycles, some noise in between.
    while (pending_accesses.size() < TARGET_ACCESSES) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 4))
          queue_access(3'($urandom_range(0, 7)), 8'($urandom));
      end else begin
        queue_command_cycle();
      end
    end
  endtask

  // Sender: presents one access per transfer and notes each accepted one.
  initial begin
    port_access_t next_access;
    bit           load;
    access_sb = new();
    in_valid = 0;
    opcode = 0;
    data_byte = 0;
    drive_ready = 0;
    accepted_count = 0;
    stimulus_done = 0;
    rst = 1;
    build_stimulus();
    hold_at = $urandom_range(TARGET_ACCESSES / 4, TARGET_ACCESSES / 2);
    repeat (6) @(posedge clk);
    rst <= 0;
    forever begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        access_sb.note_access(opcode, data_byte, drive_ready);
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        load = pending_accesses.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct();
        // Hold off once until every outstanding result has come back.
        if (accepted_count == hold_at && access_sb.expected_results.size() != 0) load = 0;
        if (load) begin
          next_access = pending_accesses.pop_front();
          opcode <= next_access.op;
          data_byte <= next_access.data;
          drive_ready <= next_access.rdy;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
          if (pending_accesses.size() == 0) stimulus_done = 1;
        end
      end
    end
  end

  // Receiver: checks every result transfer and stalls at random.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        access_sb.check_result(read_value, data_to_main, port_c_value);
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  // End of run once all results are in, or on timeout.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAIL parallel_handshake_command_engine_core");
        $finish;
      end
      if (stimulus_done && access_sb.expected_results.size() == 0) begin
        repeat (40) @(posedge clk);
        if (access_sb.mismatches == 0 && access_sb.expected_results.size() == 0) begin
          $display("PASS parallel_handshake_command_engine_core");
        end else begin
          $display("FAIL parallel_handshake_command_engine_core");
        end
        $finish;
      end
    end
  end
endmodule

// ===== parallel_handshake_command_engine_core.f =====
+incdir+rtl
rtl/phce_pkg.sv
rtl/parallel_handshake_command_engine_core.sv
test/tb_parallel_handshake_command_engine_core.sv
